// ===== rtl/ets_pkg.sv =====
package ets_pkg;

  // Kinds of result item
  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_TOKEN_END = 3'd1,
    KIND_STOP      = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_BETWEEN = 2'd0,
    PH_TOKEN   = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SEP_LO = 2'd0;
  localparam logic [1:0] REG_SEP_HI = 2'd1;
  localparam logic [1:0] REG_END_LO = 2'd2;
  localparam logic [1:0] REG_END_HI = 2'd3;

  localparam logic [63:0] SEP_LO_RESET = 64'h0000_0001_0000_3E00;
  localparam logic [63:0] SEP_HI_RESET = 64'h0;
  localparam logic [63:0] END_LO_RESET = 64'h0;
  localparam logic [63:0] END_HI_RESET = 64'h0;

  localparam int MAX_RES = 3;

  typedef struct packed {
    phase_t     phase;
    quote_t     quote;
    logic [1:0] esc_cnt;
    logic       hex;
    logic [7:0] esc_val;
  } ets_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic [1:0]         cnt;
    res_t [MAX_RES-1:0] res;
  } step_out_t;

  typedef struct packed {
    logic [63:0] sep_lo;
    logic [63:0] sep_hi;
    logic [63:0] end_lo;
    logic [63:0] end_hi;
  } char_sets_t;

endpackage

// ===== rtl/escaped_token_splitter.sv =====
// Channel  | Ports                                        | Handshake
// input    | in_byte, in_end_of_string                    | in_valid / in_ready
// result   | out_result_kind, out_byte, out_last_of_run   | out_valid / out_ready
// config   | cfg_index, cfg_data                          | cfg_we, no wait
//
// An item goes to the input register and is parsed once the result buffer is free;
// its results (zero to three) land there, one leaving per cycle while out_ready is high.
// Sustained rate: one item per cycle while items give at most one result and out_ready
// is high; an item with more results holds the input until the result buffer drains.
// Synchronous reset clears the parse state and returns the character sets to defaults.
// A stalled result side fills the input register, then in_ready drops.
module escaped_token_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ets_pkg::*;

  char_sets_t sets_r;
  ets_state_t state_r, state_nxt;
  step_out_t  step_res;
  logic       inq_valid_r;
  logic [7:0] inq_byte_r;
  logic       inq_eos_r;
  logic       buf_free, fire;

  assign fire     = inq_valid_r && buf_free;
  assign in_ready = !inq_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sets_r <= '{sep_lo: SEP_LO_RESET, sep_hi: SEP_HI_RESET,
                  end_lo: END_LO_RESET, end_hi: END_HI_RESET};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEP_LO: sets_r.sep_lo <= cfg_data;
        REG_SEP_HI: sets_r.sep_hi <= cfg_data;
        REG_END_LO: sets_r.end_lo <= cfg_data;
        REG_END_HI: sets_r.end_hi <= cfg_data;
        default:    sets_r <= sets_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_valid && in_ready) inq_valid_r <= 1'b1;
      else if (fire)            inq_valid_r <= 1'b0;
      if (fire) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte_r <= in_byte;
      inq_eos_r  <= in_end_of_string;
    end
  end

  ets_step u_step (
    .state_i (state_r),
    .byte_i  (inq_byte_r),
    .eos_i   (inq_eos_r),
    .sets_i  (sets_r),
    .state_o (state_nxt),
    .res_o   (step_res)
  );

  ets_res_buf u_res_buf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (fire),
    .load_res        (step_res),
    .free            (buf_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== rtl/ets_step.sv =====
module ets_step (
  input  ets_pkg::ets_state_t state_i,
  input  logic [7:0]          byte_i,
  input  logic                eos_i,
  input  ets_pkg::char_sets_t sets_i,
  output ets_pkg::ets_state_t state_o,
  output ets_pkg::step_out_t  res_o
);
  import ets_pkg::*;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  function automatic logic in_set(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [7:0] c);
    return !c[7] && (c[6] ? hi[c[5:0]] : lo[c[5:0]]);
  endfunction

  // {valid, digit}
  function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
    logic [4:0] d;
    d = 5'd0;
    if (c inside {[8'h30:8'h37]}) d = {1'b1, c[3:0]};
    else if (hex && c inside {8'h38, 8'h39}) d = {1'b1, c[3:0]};
    else if (hex && c inside {[8'h61:8'h66], [8'h41:8'h46]}) d = {1'b1, c[3:0] + 4'd9};
    return d;
  endfunction

  function automatic logic [7:0] ctrl_map(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      8'h61:   v = 8'd7;   // a
      8'h62:   v = 8'd8;   // b
      8'h66:   v = 8'd12;  // f
      8'h6E:   v = 8'd10;  // n
      8'h72:   v = 8'd13;  // r
      8'h74:   v = 8'd9;   // t
      8'h76:   v = 8'd11;  // v
      default: v = c;
    endcase
    return v;
  endfunction

  ets_state_t s;
  step_out_t  r;
  logic [1:0] cnt;
  logic       is_sep, is_end, do_tok, do_plain, qmatch;
  logic [4:0] dig;
  logic [7:0] acc;

  always_comb begin
    s        = state_i;
    r        = '0;
    cnt      = 2'd0;
    do_tok   = 1'b0;
    do_plain = 1'b0;
    is_sep   = in_set(sets_i.sep_lo, sets_i.sep_hi, byte_i);
    is_end   = in_set(sets_i.end_lo, sets_i.end_hi, byte_i);
    dig      = digit_val(byte_i, state_i.hex);
    acc      = state_i.hex ? {state_i.esc_val[3:0], 4'b0} : {state_i.esc_val[4:0], 3'b0};
    acc      = acc + {4'b0, dig[3:0]};
    qmatch   = (state_i.quote == Q_SINGLE && byte_i == CH_SQUOTE) ||
               (state_i.quote == Q_DOUBLE && byte_i == CH_DQUOTE);

    if (eos_i) begin
      if (state_i.phase == PH_TOKEN) begin
        if (state_i.quote != Q_NONE || state_i.esc_cnt == 2'd1 ||
            (state_i.hex && state_i.esc_cnt == 2'd2)) begin
          r.res[cnt] = '{kind: KIND_ERROR, data: 8'd0}; cnt = cnt + 2'd1;
        end else begin
          if (state_i.esc_cnt >= 2'd2) begin
            r.res[cnt] = '{kind: KIND_BYTE, data: state_i.esc_val}; cnt = cnt + 2'd1;
          end
          r.res[cnt] = '{kind: KIND_TOKEN_END, data: 8'd0}; cnt = cnt + 2'd1;
          r.res[cnt] = '{kind: KIND_DONE, data: 8'd0}; cnt = cnt + 2'd1;
        end
      end else if (state_i.phase != PH_STOPPED) begin
        r.res[cnt] = '{kind: KIND_DONE, data: 8'd0}; cnt = cnt + 2'd1;
      end
      s = '0;
    end else if (state_i.phase == PH_TOKEN) begin
      do_tok = 1'b1;
    end else if (state_i.phase != PH_STOPPED) begin
      // between tokens (unused phase code behaves the same)
      if (is_sep) begin
        s.phase = PH_BETWEEN;
      end else if (is_end) begin
        r.res[cnt] = '{kind: KIND_STOP, data: byte_i}; cnt = cnt + 2'd1;
        s.phase = PH_STOPPED;
      end else begin
        s.phase = PH_TOKEN;
        do_tok  = 1'b1;
      end
    end

    if (do_tok) begin
      if (state_i.esc_cnt == 2'd1) begin
        s.esc_val = 8'd0;
        if (byte_i inside {[8'h30:8'h37]}) begin
          s.hex     = 1'b0;
          s.esc_val = byte_i - CH_ZERO;
          s.esc_cnt = 2'd2;
        end else if (byte_i == CH_X) begin
          s.hex     = 1'b1;
          s.esc_cnt = 2'd2;
        end else begin
          r.res[cnt] = '{kind: KIND_BYTE, data: ctrl_map(byte_i)}; cnt = cnt + 2'd1;
          s.esc_cnt = 2'd0;
        end
      end else if (state_i.esc_cnt >= 2'd2) begin
        if (dig[4]) begin
          s.esc_val = acc;
          if (state_i.esc_cnt == 2'd3) begin
            r.res[cnt] = '{kind: KIND_BYTE, data: acc}; cnt = cnt + 2'd1;
            s.esc_cnt = 2'd0;
          end else begin
            s.esc_cnt = state_i.esc_cnt + 2'd1;
          end
        end else begin
          // escape cut short: flush its value, then treat the byte plainly
          r.res[cnt] = '{kind: KIND_BYTE, data: state_i.esc_val}; cnt = cnt + 2'd1;
          s.esc_cnt = 2'd0;
          do_plain  = 1'b1;
        end
      end else begin
        do_plain = 1'b1;
      end
    end

    if (do_plain) begin
      if (state_i.quote != Q_NONE && qmatch) begin
        s.quote = Q_NONE;
      end else if (state_i.quote == Q_NONE && (byte_i == CH_SQUOTE || byte_i == CH_DQUOTE)) begin
        s.quote = (byte_i == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
      end else if (byte_i == CH_BSLASH) begin
        s.esc_cnt = 2'd1;
      end else if (state_i.quote == Q_NONE) begin
        if (is_sep) begin
          r.res[cnt] = '{kind: KIND_TOKEN_END, data: 8'd0}; cnt = cnt + 2'd1;
          s.phase = PH_BETWEEN;
        end else if (is_end) begin
          r.res[cnt] = '{kind: KIND_TOKEN_END, data: 8'd0}; cnt = cnt + 2'd1;
          r.res[cnt] = '{kind: KIND_STOP, data: byte_i}; cnt = cnt + 2'd1;
          s.phase = PH_STOPPED;
        end else begin
          r.res[cnt] = '{kind: KIND_BYTE, data: byte_i}; cnt = cnt + 2'd1;
        end
      end else begin
        r.res[cnt] = '{kind: KIND_BYTE, data: byte_i}; cnt = cnt + 2'd1;
      end
    end

    r.cnt = cnt;
  end

  assign state_o = s;
  assign res_o   = r;

endmodule

// ===== rtl/ets_res_buf.sv =====
module ets_res_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ets_pkg::step_out_t load_res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_result_kind,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run
);
  import ets_pkg::*;

  res_t [MAX_RES-1:0] res_r;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [1:0]         rd_r, rd_nxt;
  logic               take, last;

  assign out_valid       = (cnt_r != 2'd0);
  assign last            = (rd_r == cnt_r - 2'd1);
  assign take            = out_valid && out_ready;
  assign free            = !out_valid || (take && last);
  assign out_result_kind = res_r[rd_r].kind;
  assign out_byte        = res_r[rd_r].data;
  assign out_last_of_run = last;

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (load) begin
      cnt_nxt = load_res.cnt;
      rd_nxt  = 2'd0;
    end else if (take) begin
      if (last) begin
        cnt_nxt = 2'd0;
        rd_nxt  = 2'd0;
      end else begin
        rd_nxt = rd_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= load_res.res;
  end

endmodule

// ===== rtl/ets_checker.sv =====
module ets_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_result_kind,
  input logic [7:0] out_byte,
  input logic       out_last_of_run
);
  import ets_pkg::*;

  // result side comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
                                $stable(out_byte) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // only token bytes and stops carry a character
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_TOKEN_END || out_result_kind == KIND_DONE ||
                  out_result_kind == KIND_ERROR) |-> out_byte == 8'd0)
    else $error("nonzero byte on a result without a character");

  // done, error and stop always close the run of an item
  a_closing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_DONE || out_result_kind == KIND_ERROR ||
                  out_result_kind == KIND_STOP) |-> out_last_of_run)
    else $error("closing result not last of its run");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind <= KIND_ERROR)
    else $error("result kind out of range");

endmodule

bind escaped_token_splitter ets_checker u_ets_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_kind (out_result_kind),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);

// ===== dv/tb_escaped_token_splitter.sv =====
`timescale 1ns / 100ps

module tb_escaped_token_splitter;
  import ets_pkg::*;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam int         HOLD_CYCLES = 60;
  localparam int         IDLE_PCT    = 23;
  localparam int         SETTLE_CYCLES = 8;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } char_item_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } parse_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_result_kind;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_SEP_LO;
  logic [63:0] cfg_data = 64'h0;

  escaped_token_splitter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Parser mirror: character sets and parse state
  logic [63:0] sep_lo_m = SEP_LO_RESET;
  logic [63:0] sep_hi_m = SEP_HI_RESET;
  logic [63:0] end_lo_m = END_LO_RESET;
  logic [63:0] end_hi_m = END_HI_RESET;
  phase_t      p_phase   = PH_BETWEEN;
  quote_t      p_quote   = Q_NONE;
  logic [1:0]  p_esc_cnt = 2'd0;
  logic        p_hex     = 1'b0;
  logic [7:0]  p_esc_val = 8'h00;

  char_item_t char_q[$];
  parse_res_t parsed_q[$];
  parse_res_t step_res[$];

  int send_idle_pct = IDLE_PCT;
  int recv_idle_pct = IDLE_PCT;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int mismatches = 0;
  int items_taken = 0;
  int results_seen = 0;
  int settings_used = 0;
  int kinds_seen[5] = '{default: 0};

  function automatic bit char_in(logic [63:0] lo, logic [63:0] hi, logic [7:0] c);
    if (c < 8'd64) return lo[c[5:0]];
    if (c < 8'd128) return hi[c[5:0]];
    return 1'b0;
  endfunction

  function automatic bit is_sep(logic [7:0] c);
    return char_in(sep_lo_m, sep_hi_m, c);
  endfunction

  function automatic bit is_end(logic [7:0] c);
    return char_in(end_lo_m, end_hi_m, c);
  endfunction

  function automatic void add_res(kind_t k, logic [7:0] d);
    parse_res_t r;
    if (step_res.size() >= MAX_RES) return;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  // value of c as a digit of the pending numeric escape, -1 if none
  function automatic int digit_of(logic [7:0] c);
    if (c >= "0" && c <= "7") return int'(c) - int'(CH_ZERO);
    if (!p_hex) return -1;
    if (c == "8" || c == "9") return int'(c) - int'(CH_ZERO);
    if (c >= "a" && c <= "f") return int'(c) - int'(8'h61) + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'(8'h41) + 10;
    return -1;
  endfunction

  function automatic void plain_char(logic [7:0] c);
    if ((p_quote == Q_SINGLE && c == CH_SQUOTE) || (p_quote == Q_DOUBLE && c == CH_DQUOTE)) begin
      p_quote = Q_NONE;
    end else if (p_quote == Q_NONE && (c == CH_SQUOTE || c == CH_DQUOTE)) begin
      p_quote = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
    end else if (c == CH_BSLASH) begin
      p_esc_cnt = 2'd1;
    end else if (p_quote == Q_NONE) begin
      if (is_sep(c)) begin
        add_res(KIND_TOKEN_END, 8'h00);
        p_phase = PH_BETWEEN;
      end else if (is_end(c)) begin
        add_res(KIND_TOKEN_END, 8'h00);
        add_res(KIND_STOP, c);
        p_phase = PH_STOPPED;
      end else begin
        add_res(KIND_BYTE, c);
      end
    end else begin
      add_res(KIND_BYTE, c);
    end
  endfunction

  function automatic void token_char(logic [7:0] c);
    logic [7:0] v;
    int d;
    if (p_esc_cnt == 2'd1) begin
      p_esc_val = 8'h00;
      if (c >= "0" && c <= "7") begin
        p_hex = 1'b0;
        p_esc_val = c - CH_ZERO;
        p_esc_cnt = 2'd2;
      end else if (c == CH_X) begin
        p_hex = 1'b1;
        p_esc_cnt = 2'd2;
      end else begin
        case (c)
          "a": v = 8'h07;
          "b": v = 8'h08;
          "f": v = 8'h0C;
          "n": v = 8'h0A;
          "r": v = 8'h0D;
          "t": v = 8'h09;
          "v": v = 8'h0B;
          default: v = c;
        endcase
        add_res(KIND_BYTE, v);
        p_esc_cnt = 2'd0;
      end
      return;
    end
    if (p_esc_cnt >= 2'd2) begin
      d = digit_of(c);
      if (d >= 0) begin
        p_esc_val = 8'(int'(p_esc_val) * (p_hex ? 16 : 8) + d);
        if (p_esc_cnt == 2'd3) begin
          add_res(KIND_BYTE, p_esc_val);
          p_esc_cnt = 2'd0;
        end else begin
          p_esc_cnt++;
        end
        return;
      end
      // digit run cut short: flush the value, then treat c as usual
      add_res(KIND_BYTE, p_esc_val);
      p_esc_cnt = 2'd0;
    end
    plain_char(c);
  endfunction

  function automatic void close_string();
    if (p_phase == PH_TOKEN) begin
      if (p_quote != Q_NONE || p_esc_cnt == 2'd1 || (p_hex && p_esc_cnt == 2'd2)) begin
        add_res(KIND_ERROR, 8'h00);
      end else begin
        if (p_esc_cnt >= 2'd2) add_res(KIND_BYTE, p_esc_val);
        add_res(KIND_TOKEN_END, 8'h00);
        add_res(KIND_DONE, 8'h00);
      end
    end else if (p_phase != PH_STOPPED) begin
      add_res(KIND_DONE, 8'h00);
    end
    p_phase = PH_BETWEEN;
    p_quote = Q_NONE;
    p_esc_cnt = 2'd0;
    p_hex = 1'b0;
    p_esc_val = 8'h00;
  endfunction

  function automatic void parse_step(logic [7:0] c, logic eos);
    step_res.delete();
    if (eos) begin
      close_string();
    end else if (p_phase == PH_TOKEN) begin
      token_char(c);
    end else if (p_phase != PH_STOPPED && !is_sep(c)) begin
      if (is_end(c)) begin
        add_res(KIND_STOP, c);
        p_phase = PH_STOPPED;
      end else begin
        p_phase = PH_TOKEN;
        token_char(c);
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) parsed_q.push_back(step_res[i]);
  endfunction

  // Sender
  always @(posedge clk) begin : feed
    char_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_step(in_byte, in_end_of_string);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (char_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = char_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.ch;
          in_end_of_string <= nxt.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin : sink
    parse_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (out_result_kind < 3'd5) kinds_seen[out_result_kind]++;
        if (parsed_q.size() == 0) begin
          $error("unexpected result: kind %0d byte %02h last %0b",
                 out_result_kind, out_byte, out_last_of_run);
          mismatches++;
        end else begin
          want = parsed_q.pop_front();
          results_seen++;
          if (out_result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, out_result_kind);
            mismatches++;
          end
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            mismatches++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_byte(logic [7:0] c);
    char_item_t it;
    it.ch = c;
    it.eos = 1'b0;
    char_q.push_back(it);
  endtask

  // terminator; the byte lane carries junk that must be ignored
  task automatic push_eos();
    char_item_t it;
    it.ch = 8'($urandom_range(255));
    it.eos = 1'b1;
    char_q.push_back(it);
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  task automatic pick_from(string pool);
    push_byte(pool[$urandom_range(pool.len() - 1)]);
  endtask

  // one string: mostly well-formed tokens, sometimes raw noise or cut short
  task automatic push_random_string();
    string word_chars = "abcfnrtvxAFgz0189_-";
    string quoted_chars = "ab \t'\"\\;|x7";
    string esc_chars = "abfnrtv\\'\"qz;";
    string hex_chars = "0123456789abcdefABCDEFgG";
    string sep_chars = " \t\n\v\f";
    logic [7:0] q;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
      if ($urandom_range(1)) push_eos();
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(9))
        0, 1, 2: repeat ($urandom_range(1, 3)) pick_from(word_chars);
        3: pick_from(sep_chars);
        4: begin
          q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
          push_byte(q);
          repeat ($urandom_range(0, 3)) pick_from(quoted_chars);
          if ($urandom_range(9) != 0) push_byte(q);
        end
        5: begin
          push_byte(CH_BSLASH);
          if ($urandom_range(4) != 0) pick_from(esc_chars);
        end
        6: begin
          push_byte(CH_BSLASH);
          repeat ($urandom_range(1, 4)) push_byte(CH_ZERO + 8'($urandom_range(7)));
        end
        7: begin
          push_byte(CH_BSLASH);
          push_byte(CH_X);
          repeat ($urandom_range(0, 3)) pick_from(hex_chars);
        end
        8: pick_from(";|");
        default: push_byte(8'($urandom_range(255)));
      endcase
    end
    if ($urandom_range(9) != 0) push_eos();
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SEP_LO: sep_lo_m = val;
      REG_SEP_HI: sep_hi_m = val;
      REG_END_LO: end_lo_m = val;
      REG_END_HI: end_hi_m = val;
      default: ;
    endcase
  endtask

  task automatic set_char_sets(logic [63:0] sl, logic [63:0] sh, logic [63:0] el,
                               logic [63:0] eh);
    write_reg(REG_SEP_LO, sl);
    write_reg(REG_SEP_HI, sh);
    write_reg(REG_END_LO, el);
    write_reg(REG_END_HI, eh);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // waits until the sender is empty and every predicted result is back, then the pipe settles
  task automatic wait_drained();
    do @(negedge clk); while (char_q.size() > 0 || in_valid || parsed_q.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(int n_items);
    int target;
    @(negedge clk);
    target = char_q.size() + n_items;
    while (char_q.size() < target) push_random_string();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ';' and '|' stop; space is in both sets and must act as a separator
    set_char_sets(SEP_LO_RESET, SEP_HI_RESET, (64'd1 << 59) | (64'd1 << 32), 64'd1 << 60);
    @(negedge clk);
    push_eos();
    push_text("a b");
    push_eos();
    push_text("''");
    push_eos();
    push_text("\\x4g");
    push_eos();
    push_text("\\12;z");
    push_eos();
    push_text("\\n");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("\"a");
    push_eos();
    push_text("\\");
    push_eos();
    wait_drained();

    // stall the result side long enough for the input to back up
    run_random(30);
    @(negedge clk);
    hold_requests++;
    wait_drained();

    // everything below 128 separates; no idling on either side
    set_char_sets('1, '1, '0, '0);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(25);
    wait_drained();
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;

    set_char_sets('0, '0, '1, '1);
    run_random(20);
    wait_drained();

    set_char_sets({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom} & {$urandom, $urandom},
                  {$urandom, $urandom} & {$urandom, $urandom});
    run_random(20);
    wait_drained();

    set_char_sets('0, '0, '0, '0);
    run_random(20);
    wait_drained();

    $display("Parsed %0d items into %0d results under %0d character-set settings",
             items_taken, results_seen, settings_used);
    $display("Results by kind (byte/end/stop/done/error): %0d/%0d/%0d/%0d/%0d",
             kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3], kinds_seen[4]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d items queued and %0d results outstanding",
             char_q.size(), parsed_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
